@@ rtl/bounded_vector_engine_top_assert.svh @@
// Assertion macros shared by the bounded vector engine RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef BOUNDED_VECTOR_ENGINE_TOP_ASSERT_SVH
`define BOUNDED_VECTOR_ENGINE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Invariant that must hold at every clock edge out of reset.
`define BVE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bve check failed: invariant");
// Same-cycle implication.
`define BVE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bve check failed: implication");
// Next-cycle implication.
`define BVE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bve check failed: next-cycle implication");
`else
`define BVE_ASSERT(lbl, clk, rst_n, prop)
`define BVE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define BVE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/bve_pkg.sv @@
// Shared types and constants of the bounded vector engine.
// No dependencies; used by bve_ctrl, bve_dpath and the top level.
`default_nettype none

package bve_pkg;

    localparam int OP_W      = 3;
    localparam int IDX_W     = 5;
    localparam int VAL_W     = 32;
    localparam int ST_W      = 2;
    localparam int DATA_W    = 32;
    localparam int LEN_W     = 5;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    // Command opcodes
    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_POP    = 3'd1;
    localparam logic [OP_W-1:0] OP_GET    = 3'd2;
    localparam logic [OP_W-1:0] OP_SET    = 3'd3;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd4;
    localparam logic [OP_W-1:0] OP_ERASE  = 3'd5;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_BADARG = 2'd1;
    localparam logic [ST_W-1:0] ST_BOUNDS = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic load;      // latch the accepted request
        logic decide;    // register status code, set up the shift
        logic rd_elem;   // read the addressed element
        logic cap_data;  // hold the read element for the result
        logic shift;     // advance the shift one entry
        logic wr_val;    // write the request value
        logic cnt_inc;
        logic cnt_dec;
        logic result;    // load the output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            err;
        logic            shift_done;
        logic            out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

@@ rtl/bve_dpath.sv @@
// Datapath of the bounded vector engine: element memory, length count,
// shift sequencing and output register. Depends on bve_pkg.
`default_nettype none
`include "bounded_vector_engine_top_assert.svh"

module bve_dpath #(
    parameter int DEPTH      = 16,
    parameter int ELEM_WIDTH = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire bve_pkg::t_dp_cmd            i_cmd,
    output      bve_pkg::t_dp_sts            o_sts,
    input  wire logic [bve_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  wire logic                        i_m_tready,
    output      logic                        o_m_tvalid,
    output      logic [bve_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import bve_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;

    logic [ELEM_WIDTH-1:0] r_mem [DEPTH];

    logic [OP_W-1:0]       r_op;
    logic [IDX_W-1:0]      r_idx;
    logic [VAL_W-1:0]      r_val;
    logic [CW-1:0]         r_count;
    logic [ST_W-1:0]       r_code;
    logic [ELEM_WIDTH-1:0] r_hold;
    logic [ELEM_WIDTH-1:0] r_rd_data;
    logic [CW-1:0]         r_left;
    logic [AW-1:0]         r_src;
    logic [AW-1:0]         r_dst;
    logic [AW-1:0]         r_wr_addr;
    logic                  r_wr_pend;
    logic                  r_m_valid;
    logic [ST_W-1:0]       r_m_status;
    logic [DATA_W-1:0]     r_m_data;
    logic [LEN_W-1:0]      r_m_len;

    logic [XW-1:0]         w_cnt_x;
    logic [XW-1:0]         w_idx_x;
    logic [XW-1:0]         w_last_x;
    logic [XW-1:0]         w_idx_p1;
    logic [XW-1:0]         w_ins_left;
    logic [XW-1:0]         w_ers_left;
    logic [ST_W-1:0]       w_code;
    logic [63:0]           w_val64;
    logic [63:0]           w_hold64;
    logic [ELEM_WIDTH-1:0] w_val_e;
    logic [AW-1:0]         w_elem_addr;
    logic [AW-1:0]         w_val_addr;
    logic [AW-1:0]         w_rd_addr;
    logic                  w_rd_en;
    logic                  w_shift_go;
    logic                  w_we;
    logic [AW-1:0]         w_wa;
    logic [ELEM_WIDTH-1:0] w_wd;

    assign w_cnt_x    = XW'(r_count);
    assign w_idx_x    = XW'(r_idx);
    assign w_last_x   = w_cnt_x - XW'(1);
    assign w_idx_p1   = w_idx_x + XW'(1);
    assign w_ins_left = w_cnt_x - w_idx_x;
    assign w_ers_left = w_cnt_x - w_idx_p1;
    assign w_val64    = 64'(r_val);
    assign w_val_e    = w_val64[ELEM_WIDTH-1:0];
    assign w_hold64   = 64'(r_hold);

    // Status of the latched request against the current length
    always_comb begin
        w_code = ST_OK;
        unique case (r_op)
            OP_PUSH:   if (w_cnt_x == XW'(DEPTH)) w_code = ST_FULL;
            OP_POP:    if (r_count == '0) w_code = ST_BOUNDS;
            OP_GET:    if (w_idx_x >= w_cnt_x) w_code = ST_BOUNDS;
            OP_SET:    if (w_idx_x >= w_cnt_x) w_code = ST_BADARG;
            OP_INSERT: begin
                if (w_idx_x > w_cnt_x) begin
                    w_code = ST_BOUNDS;
                end else if (w_cnt_x == XW'(DEPTH)) begin
                    w_code = ST_FULL;
                end
            end
            OP_ERASE:  if (w_idx_x >= w_cnt_x) w_code = ST_BOUNDS;
            default:   w_code = ST_BADARG;
        endcase
    end

    assign w_elem_addr = (r_op == OP_POP) ? w_last_x[AW-1:0] : w_idx_x[AW-1:0];
    assign w_val_addr  = (r_op == OP_PUSH) ? w_cnt_x[AW-1:0] : w_idx_x[AW-1:0];
    assign w_shift_go  = i_cmd.shift && (r_left != '0);
    assign w_rd_en     = i_cmd.rd_elem || w_shift_go;
    assign w_rd_addr   = i_cmd.rd_elem ? w_elem_addr : r_src;

    // Pending shift write has the port; value write otherwise
    assign w_we = r_wr_pend || i_cmd.wr_val;
    assign w_wa = r_wr_pend ? r_wr_addr : w_val_addr;
    assign w_wd = r_wr_pend ? r_rd_data : w_val_e;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // Request latch, result hold, shift pointers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_s_tdata[OP_W-1:0];
            r_idx  <= i_s_tdata[OP_W+IDX_W-1:OP_W];
            r_val  <= i_s_tdata[OP_W+IDX_W+VAL_W-1:OP_W+IDX_W];
            r_hold <= '0;
        end
        if (i_cmd.cap_data) begin
            r_hold <= r_rd_data;
        end
        if (i_cmd.decide) begin
            r_code <= w_code;
            if (r_op == OP_INSERT) begin
                r_src <= w_last_x[AW-1:0];
                r_dst <= w_cnt_x[AW-1:0];
            end else begin
                r_src <= w_idx_p1[AW-1:0];
                r_dst <= w_idx_x[AW-1:0];
            end
        end else if (w_shift_go) begin
            if (r_op == OP_INSERT) begin
                r_src <= r_src - AW'(1);
                r_dst <= r_dst - AW'(1);
            end else begin
                r_src <= r_src + AW'(1);
                r_dst <= r_dst + AW'(1);
            end
        end
        if (w_shift_go) begin
            r_wr_addr <= r_dst;
        end
        if (i_cmd.result) begin
            r_m_status <= r_code;
            r_m_data   <= w_hold64[DATA_W-1:0];
            r_m_len    <= w_cnt_x[LEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_left    <= '0;
            r_wr_pend <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.decide) begin
                if (w_code != ST_OK) begin
                    r_left <= '0;
                end else if (r_op == OP_INSERT) begin
                    r_left <= w_ins_left[CW-1:0];
                end else if (r_op == OP_ERASE) begin
                    r_left <= w_ers_left[CW-1:0];
                end else begin
                    r_left <= '0;
                end
            end else if (w_shift_go) begin
                r_left <= r_left - CW'(1);
            end
            r_wr_pend <= w_shift_go;
            if (i_cmd.result) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_sts.op         = r_op;
    assign o_sts.err        = (w_code != ST_OK);
    assign o_sts.shift_done = (r_left == '0) && !r_wr_pend;
    assign o_sts.out_free   = !r_m_valid || i_m_tready;

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {1'b0, r_m_len, r_m_data, r_m_status};

    `BVE_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= CW'(DEPTH))
    `BVE_ASSERT_IMPL(a_port_free, i_clk, i_rst_n, r_wr_pend, !i_cmd.wr_val)
    `BVE_ASSERT_IMPL(a_out_slot, i_clk, i_rst_n, i_cmd.result, !r_m_valid || i_m_tready)

endmodule

`default_nettype wire

@@ rtl/bve_ctrl.sv @@
// Controller of the bounded vector engine: sequences one request at a time
// through decode, element access, shifting and result. Depends on bve_pkg.
`default_nettype none
`include "bounded_vector_engine_top_assert.svh"

module bve_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    output      logic             o_s_tready,
    input  wire bve_pkg::t_dp_sts i_sts,
    output      bve_pkg::t_dp_cmd o_cmd
);
    import bve_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_CAPT   = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_FILL   = 3'd4;
    localparam logic [2:0] S_RESP   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = S_RESP;
                if (!i_sts.err) begin
                    case (i_sts.op) inside
                        OP_PUSH: begin
                            o_cmd.wr_val  = 1'b1;
                            o_cmd.cnt_inc = 1'b1;
                        end
                        OP_SET: o_cmd.wr_val = 1'b1;
                        OP_POP, OP_ERASE: begin
                            o_cmd.rd_elem = 1'b1;
                            o_cmd.cnt_dec = 1'b1;
                            n_state       = S_CAPT;
                        end
                        OP_GET: begin
                            o_cmd.rd_elem = 1'b1;
                            n_state       = S_CAPT;
                        end
                        OP_INSERT: begin
                            o_cmd.cnt_inc = 1'b1;
                            n_state       = S_SHIFT;
                        end
                        default: n_state = S_RESP;
                    endcase
                end
            end
            S_CAPT: begin
                o_cmd.cap_data = 1'b1;
                n_state = (i_sts.op == OP_ERASE) ? S_SHIFT : S_RESP;
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_sts.shift_done) begin
                    n_state = (i_sts.op == OP_INSERT) ? S_FILL : S_RESP;
                end
            end
            S_FILL: begin
                o_cmd.wr_val = 1'b1;
                n_state      = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.result = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

    `BVE_ASSERT_NEXT(a_accept_decide, i_clk, i_rst_n, o_cmd.load, r_state == S_DECIDE)

endmodule

`default_nettype wire

@@ rtl/bounded_vector_engine_top.sv @@
// Top level of the bounded vector engine: request and result stream ports,
// controller and datapath. Depends on bve_pkg, bve_ctrl and bve_dpath.
//
//  Channel   Direction  Payload (tdata, lowest bit first)
//  s_*       in         operation[2:0], index[7:3], value[39:8]
//  m_*       out        status[1:0], data[33:2], length[38:34], zero[39]
//
// One request is worked at a time. After the accept, push, set and failing requests go
// from decode straight to the result register; pop and get first read and capture the
// element; erase reads and captures it and then shifts, insert shifts and then writes
// its value. Moved entries: count - index for insert, count - index - 1 for erase; the
// element memory moves one entry per cycle through its single read and write port, each
// write-back registered behind its read.
// Reset (synchronous, active low) empties the vector; element storage is
// not cleared. A stalled result holds in the output register while the
// next request is accepted and worked up to its own result.
`default_nettype none

module bounded_vector_engine_top #(
    parameter int DEPTH      = 16,
    parameter int ELEM_WIDTH = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output      logic                          o_s_tready,
    // operation [2:0], index [7:3], value [39:8]
    input  wire logic [bve_pkg::S_TDATA_W-1:0] i_s_tdata,
    output      logic                          o_m_tvalid,
    input  wire logic                          i_m_tready,
    // status [1:0], data [33:2], length [38:34], zero fill [39]
    output      logic [bve_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import bve_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequence each request through decode, access, shift and result
    bve_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Hold the elements, the length and the result register
    bve_dpath #(
        .DEPTH      (DEPTH),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_s_tdata  (i_s_tdata),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

`default_nettype wire
